/* rtl/rucee_pkg.sv */
// ----------------------------------------------------------------------------
// rucee_pkg
// Shared widths for the ray versus grid cell entry/exit pipeline.
// ----------------------------------------------------------------------------
package rucee_pkg;

    localparam int POS_W   = 32;
    localparam int DIR_W   = 16;
    localparam int CELL_W  = 16;
    localparam int PARAM_W = 32;

    localparam int S_TDATA_W = 2 * POS_W + 2 * DIR_W + 2 * CELL_W;  // 128
    localparam int M_TDATA_W = 72;                                   // 65 bits used

    localparam logic signed [PARAM_W-1:0] PARAM_MAX = {1'b0, {(PARAM_W-1){1'b1}}};
    localparam logic signed [PARAM_W-1:0] PARAM_MIN = {1'b1, {(PARAM_W-1){1'b0}}};

endpackage

/* rtl/rucee_div.sv */
// ----------------------------------------------------------------------------
// rucee_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Carries a tag alongside the operands.
// ----------------------------------------------------------------------------
module rucee_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 16,
    parameter int TAG_W = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [NUM_W-1:0] quo,
    output logic [TAG_W-1:0]        out_tag
);

    localparam int ST = NUM_W + 1;

    logic [NUM_W-1:0] q_reg   [ST];
    logic [DEN_W-1:0] r_reg   [ST];
    logic [DEN_W-1:0] d_reg   [ST];
    logic             neg_reg [ST];
    logic [TAG_W-1:0] tag_reg [ST];
    logic [ST-1:0]    v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]   <= num[NUM_W-1] ? NUM_W'(-num) : num;
            d_reg[0]   <= den[DEN_W-1] ? DEN_W'(-den) : den;
            r_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 1; k < ST; k++) begin : g_stage
        logic [DEN_W:0] r_next;
        logic [DEN_W:0] diff;
        always_comb begin
            r_next = {r_reg[k-1], q_reg[k-1][NUM_W-1]};
            diff   = r_next - {1'b0, d_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
                if (!diff[DEN_W]) begin
                    r_reg[k] <= diff[DEN_W-1:0];
                    q_reg[k] <= {q_reg[k-1][NUM_W-2:0], 1'b1};
                end else begin
                    r_reg[k] <= r_next[DEN_W-1:0];
                    q_reg[k] <= {q_reg[k-1][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[ST-1];
    assign quo       = neg_reg[ST-1] ? NUM_W'(-q_reg[ST-1]) : q_reg[ST-1];
    assign out_tag   = tag_reg[ST-1];

endmodule

/* rtl/rucee_edge.sv */
// ----------------------------------------------------------------------------
// rucee_edge
// Edge crossing test by cross multiplication, registered after the
// products and after the compares.
// ----------------------------------------------------------------------------
module rucee_edge #(
    parameter int D_W = 50
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [D_W-1:0]  d_a,
    input  logic signed [D_W-1:0]  lo_o,
    input  logic signed [D_W-1:0]  hi_o,
    input  logic signed [15:0]     dir_a,
    input  logic signed [15:0]     dir_o,
    output logic                   crossed
);

    localparam int P_W = D_W + 16;

    logic signed [P_W-1:0] num_reg, lo_reg, hi_reg;
    logic                  pos_reg, pos2_reg;
    logic                  c1_reg, c2_reg, c3_reg, c4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= P_W'(d_a)  * P_W'(dir_o);
            lo_reg   <= P_W'(lo_o) * P_W'(dir_a);
            hi_reg   <= P_W'(hi_o) * P_W'(dir_a);
            pos_reg  <= !dir_a[15];
            c1_reg   <= lo_reg <= num_reg;
            c2_reg   <= num_reg <= hi_reg;
            c3_reg   <= hi_reg <= num_reg;
            c4_reg   <= num_reg <= lo_reg;
            pos2_reg <= pos_reg;
        end
    end

    assign crossed = pos2_reg ? (c1_reg && c2_reg) : (c3_reg && c4_reg);

endmodule

/* rtl/ray_unit_cell_entry_exit_core.sv */
// ----------------------------------------------------------------------------
// ray_unit_cell_entry_exit_core
// Ray versus unit grid cell: hit flag, entry and exit parameters.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output side takes results;
// each result passes through the input stage, the bit-per-stage divider
// pipelines (one per cell edge), the min/max stage and the output stage on
// its way to m_tvalid. A stall freezes every stage. Parameters truncate
// toward zero and saturate to 32 bits; a miss reports zero entry and exit.
module ray_unit_cell_entry_exit_core #(
    parameter int POS_FRAC_BITS = 16,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, dir_x, dir_y, cell_x, cell_y
    input  logic [rucee_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, entry_param, exit_param, zero fill
    output logic [rucee_pkg::M_TDATA_W-1:0] m_tdata
);

    import rucee_pkg::*;

    localparam int D_W   = 50;
    localparam int NUM_W = D_W + DIR_FRAC_BITS;
    localparam int LAT   = NUM_W + 1;

    logic en;
    logic out_v_reg;
    logic [M_TDATA_W-1:0] out_reg;
    logic pipe_v;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // stage 1: edge distances
    logic                   v1_reg;
    logic signed [D_W-1:0]  dx0_reg, dx1_reg, dy0_reg, dy1_reg;
    logic signed [D_W-1:0]  lx0_reg, lx1_reg, ly0_reg, ly1_reg;
    logic signed [15:0]     dirx_reg, diry_reg;

    logic signed [31:0] sx, sy;
    logic signed [15:0] dx, dy, cx, cy;
    logic signed [D_W-1:0] x0, x1, y0, y1;
    always_comb begin
        sx = s_tdata[31:0];
        sy = s_tdata[63:32];
        dx = s_tdata[79:64];
        dy = s_tdata[95:80];
        cx = s_tdata[111:96];
        cy = s_tdata[127:112];
        x0 = D_W'(cx) <<< POS_FRAC_BITS;
        x1 = (D_W'(cx) + D_W'(1)) <<< POS_FRAC_BITS;
        y0 = D_W'(cy) <<< POS_FRAC_BITS;
        y1 = (D_W'(cy) + D_W'(1)) <<< POS_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx0_reg  <= x0 - D_W'(sx);
            dx1_reg  <= x1 - D_W'(sx);
            dy0_reg  <= y0 - D_W'(sy);
            dy1_reg  <= y1 - D_W'(sy);
            lx0_reg  <= x0 - D_W'(sx);
            lx1_reg  <= x1 - D_W'(sx);
            ly0_reg  <= y0 - D_W'(sy);
            ly1_reg  <= y1 - D_W'(sy);
            dirx_reg <= dx;
            diry_reg <= dy;
        end
    end

    // crossing tests, 2 stages, then delayed to divider latency
    logic ins [4];
    rucee_edge #(.D_W(D_W)) u_e0 (.aclk, .en, .d_a(dx0_reg), .lo_o(ly0_reg),
        .hi_o(ly1_reg), .dir_a(dirx_reg), .dir_o(diry_reg), .crossed(ins[0]));
    rucee_edge #(.D_W(D_W)) u_e1 (.aclk, .en, .d_a(dx1_reg), .lo_o(ly0_reg),
        .hi_o(ly1_reg), .dir_a(dirx_reg), .dir_o(diry_reg), .crossed(ins[1]));
    rucee_edge #(.D_W(D_W)) u_e2 (.aclk, .en, .d_a(dy0_reg), .lo_o(lx0_reg),
        .hi_o(lx1_reg), .dir_a(diry_reg), .dir_o(dirx_reg), .crossed(ins[2]));
    rucee_edge #(.D_W(D_W)) u_e3 (.aclk, .en, .d_a(dy1_reg), .lo_o(lx0_reg),
        .hi_o(lx1_reg), .dir_a(diry_reg), .dir_o(dirx_reg), .crossed(ins[3]));

    logic nzx_reg [2];
    logic nzy_reg [2];
    always_ff @(posedge aclk) begin
        if (en) begin
            nzx_reg[0] <= dirx_reg != '0;
            nzy_reg[0] <= diry_reg != '0;
            nzx_reg[1] <= nzx_reg[0];
            nzy_reg[1] <= nzy_reg[0];
        end
    end

    logic [3:0] ok;
    assign ok = {ins[3] & nzy_reg[1], ins[2] & nzy_reg[1],
                 ins[1] & nzx_reg[1], ins[0] & nzx_reg[1]};

    localparam int DLY = LAT - 2;
    logic [3:0] okd_reg [DLY];
    always_ff @(posedge aclk) begin
        if (en) begin
            okd_reg[0] <= ok;
            for (int k = 1; k < DLY; k++) okd_reg[k] <= okd_reg[k-1];
        end
    end

    // dividers
    logic signed [NUM_W-1:0] q [4];
    logic                    qv [4];
    logic                    tg [4];
    logic signed [D_W-1:0]   dd [4];
    logic signed [15:0]      dv [4];
    assign dd[0] = dx0_reg; assign dv[0] = dirx_reg;
    assign dd[1] = dx1_reg; assign dv[1] = dirx_reg;
    assign dd[2] = dy0_reg; assign dv[2] = diry_reg;
    assign dd[3] = dy1_reg; assign dv[3] = diry_reg;

    for (genvar i = 0; i < 4; i++) begin : g_div
        rucee_div #(.NUM_W(NUM_W), .DEN_W(16), .TAG_W(1)) u_div (
            .aclk, .aresetn, .en, .in_valid(v1_reg),
            .num(NUM_W'(dd[i]) <<< DIR_FRAC_BITS), .den(dv[i]),
            .in_tag(1'b0), .out_valid(qv[i]), .quo(q[i]), .out_tag(tg[i]));
    end

    assign pipe_v = qv[0] && !tg[0];

    // pairwise min/max per axis, then merge and saturation
    logic                      va_reg;
    logic                      p0_ok_reg, p1_ok_reg;
    logic signed [NUM_W-1:0]   p0_lo_reg, p0_hi_reg, p1_lo_reg, p1_hi_reg;
    logic                      hit;
    logic signed [NUM_W-1:0]   lo, hi;
    logic signed [PARAM_W-1:0] lo_s, hi_s;
    logic [3:0]                okf;

    assign okf = okd_reg[DLY-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= pipe_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_ok_reg <= okf[0] || okf[1];
            p1_ok_reg <= okf[2] || okf[3];
            p0_lo_reg <= (okf[0] && (!okf[1] || q[0] < q[1])) ? q[0] : q[1];
            p0_hi_reg <= (okf[0] && (!okf[1] || q[0] > q[1])) ? q[0] : q[1];
            p1_lo_reg <= (okf[2] && (!okf[3] || q[2] < q[3])) ? q[2] : q[3];
            p1_hi_reg <= (okf[2] && (!okf[3] || q[2] > q[3])) ? q[2] : q[3];
        end
    end

    always_comb begin
        hit = p0_ok_reg || p1_ok_reg;
        lo  = '0;
        hi  = '0;
        if (p0_ok_reg && p1_ok_reg) begin
            lo = (p0_lo_reg < p1_lo_reg) ? p0_lo_reg : p1_lo_reg;
            hi = (p0_hi_reg > p1_hi_reg) ? p0_hi_reg : p1_hi_reg;
        end else if (p0_ok_reg) begin
            lo = p0_lo_reg;
            hi = p0_hi_reg;
        end else if (p1_ok_reg) begin
            lo = p1_lo_reg;
            hi = p1_hi_reg;
        end
        lo_s = (lo > NUM_W'(PARAM_MAX)) ? PARAM_MAX :
               (lo < NUM_W'(PARAM_MIN)) ? PARAM_MIN : lo[PARAM_W-1:0];
        hi_s = (hi > NUM_W'(PARAM_MAX)) ? PARAM_MAX :
               (hi < NUM_W'(PARAM_MIN)) ? PARAM_MIN : hi[PARAM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {{(M_TDATA_W-65){1'b0}}, hi_s, lo_s, hit};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule
